// ----- src/best_fit_heap_allocator_core_macros.svh -----
// Assertion macros for the best-fit allocator checker
`ifndef BEST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`define BEST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication under reset
`define BFHA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("allocator port check failed");

// next-cycle implication under reset
`define BFHA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("allocator port check failed");

`endif

// ----- src/bfha_pkg.sv -----
// Shared types, constants and command codes of the best-fit allocator
`timescale 1ns / 1ps
`default_nettype none
package bfha_pkg;

  localparam int FREE_DEPTH = 32;
  localparam int USED_DEPTH = 32;
  localparam int IDX_W      = 5;
  localparam int CNT_W      = 6;

  typedef logic [15:0]      addr_t;
  typedef logic [16:0]      len_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam len_t  HDR_LEN   = 17'd16;
  localparam addr_t HDR_ADDR  = 16'd16;
  localparam len_t  ARENA_MAX = 17'd65536;
  localparam cnt_t  FREE_CAP  = cnt_t'(FREE_DEPTH);
  localparam cnt_t  USED_CAP  = cnt_t'(USED_DEPTH);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_ASCAN,
    OP_AGRANT,
    OP_SHDN,
    OP_USCAN,
    OP_FPOS,
    OP_FREL,
    OP_SHUP
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       res_en;
    logic [1:0] res_status;
    logic       res_alloc;
  } cmd_t;

  typedef struct packed {
    logic at_end;
    logic hit;
    logic found;
    logic zero_bytes;
    logic used_full;
    logic full;
    logic both;
    logic neither;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- src/bfha_ctrl.sv -----
// Request sequencer of the best-fit allocator
`timescale 1ns / 1ps
`default_nettype none
module bfha_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  input  wire logic [1:0]    s_req_i,
  input  wire bfha_pkg::sts_t sts_i,
  output logic               s_ready_o,
  output bfha_pkg::cmd_t     cmd_o
);
  import bfha_pkg::*;

  localparam logic [3:0] S_BOOT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_ASCAN  = 4'd2;
  localparam logic [3:0] S_AGRANT = 4'd3;
  localparam logic [3:0] S_SHDN   = 4'd4;
  localparam logic [3:0] S_USCAN  = 4'd5;
  localparam logic [3:0] S_FPOS   = 4'd6;
  localparam logic [3:0] S_FREL   = 4'd7;
  localparam logic [3:0] S_SHUP   = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;

  logic [3:0] state_q, state_d;
  logic [1:0] res_q, res_d;
  logic       alloc_q, alloc_d;

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d          = state_q;
    res_d            = res_q;
    alloc_d          = alloc_q;
    cmd_o.op         = OP_NONE;
    cmd_o.res_en     = 1'b0;
    cmd_o.res_status = res_q;
    cmd_o.res_alloc  = alloc_q;
    unique case (state_q)
      S_BOOT: begin
        cmd_o.op = OP_INIT;
        state_d  = S_IDLE;
      end
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.op = OP_LOAD;
          alloc_d  = 1'b0;
          state_d  = S_FINISH;
          unique case (s_req_i)
            REQ_ALLOC: begin
              if (sts_i.zero_bytes) begin
                res_d = ST_BAD;
              end else if (sts_i.used_full) begin
                res_d = ST_FULL;
              end else begin
                state_d = S_ASCAN;
              end
            end
            REQ_FREE: begin
              state_d = S_USCAN;
            end
            REQ_INIT: begin
              cmd_o.op = OP_INIT;
              res_d    = ST_OK;
            end
            default: begin
              res_d = ST_BAD;
            end
          endcase
        end
      end
      S_ASCAN: begin
        cmd_o.op = OP_ASCAN;
        if (sts_i.at_end) begin
          if (sts_i.found) begin
            state_d = S_AGRANT;
          end else begin
            res_d   = ST_NOFIT;
            state_d = S_FINISH;
          end
        end
      end
      S_AGRANT: begin
        cmd_o.op = OP_AGRANT;
        res_d    = ST_OK;
        alloc_d  = 1'b1;
        state_d  = sts_i.hit ? S_SHDN : S_FINISH;
      end
      S_SHDN: begin
        cmd_o.op = OP_SHDN;
        if (sts_i.at_end) begin
          state_d = S_FINISH;
        end
      end
      S_USCAN: begin
        cmd_o.op = OP_USCAN;
        if (sts_i.at_end) begin
          res_d   = ST_BAD;
          state_d = S_FINISH;
        end else if (sts_i.hit) begin
          state_d = S_FPOS;
        end
      end
      S_FPOS: begin
        cmd_o.op = OP_FPOS;
        if (sts_i.hit) begin
          state_d = S_FREL;
        end
      end
      S_FREL: begin
        cmd_o.op = OP_FREL;
        if (sts_i.full) begin
          res_d   = ST_FULL;
          state_d = S_FINISH;
        end else begin
          res_d = ST_OK;
          if (sts_i.both) begin
            state_d = S_SHDN;
          end else if (sts_i.neither) begin
            state_d = S_SHUP;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_SHUP: begin
        cmd_o.op = OP_SHUP;
        if (sts_i.at_end) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.res_en = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BOOT;
      res_q   <= ST_OK;
      alloc_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      alloc_q <= alloc_d;
    end
  end

endmodule
`default_nettype wire

// ----- src/bfha_datapath.sv -----
// Segment tables, counters, scan registers and result register of the allocator
`timescale 1ns / 1ps
`default_nettype none
module bfha_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [16:0]    cfg_wdata_i,
  input  wire bfha_pkg::addr_t alloc_bytes_i,
  input  wire bfha_pkg::addr_t free_addr_i,
  input  wire bfha_pkg::cmd_t cmd_i,
  output bfha_pkg::sts_t      sts_o,
  input  wire logic           m_ready_i,
  output logic                m_valid_o,
  output logic [1:0]          m_status_o,
  output bfha_pkg::addr_t     m_addr_o
);
  import bfha_pkg::*;

  addr_t free_start_q [FREE_DEPTH];
  len_t  free_len_q   [FREE_DEPTH];
  addr_t used_start_q [USED_DEPTH];
  len_t  used_len_q   [USED_DEPTH];

  len_t       arena_q;
  cnt_t       fcnt_q, ucnt_q, idx_q, pos_q;
  idx_t       best_q, u_q;
  len_t       best_len_q, need_q, seg_len_q, prev_end_q, prev_len_q, next_len_q;
  addr_t      user_q, seg_start_q, addr_q;
  logic       found_q, pt_q, nt_q;
  logic       out_valid_q;
  logic [1:0] out_status_q;
  addr_t      out_addr_q;

  idx_t  f_raddr, u_raddr, pos_m1;
  addr_t f_rd_start, u_rd_start;
  len_t  f_rd_len, u_rd_len, rest, init_size, seg_end;
  cnt_t  idx_p1;
  logic  idx_lt_f, idx1_lt_f, fpos_stop, uhit, need_remove, pt_c, nt_c, full_c;

  always_comb begin
    case (cmd_i.op)
      OP_AGRANT: f_raddr = best_q;
      OP_SHDN:   f_raddr = idx_q[IDX_W-1:0] + idx_t'(1);
      OP_SHUP:   f_raddr = idx_q[IDX_W-1:0] - idx_t'(1);
      default:   f_raddr = idx_q[IDX_W-1:0];
    endcase
    case (cmd_i.op)
      OP_FREL: u_raddr = ucnt_q[IDX_W-1:0] - idx_t'(1);
      default: u_raddr = idx_q[IDX_W-1:0];
    endcase
  end

  assign f_rd_start  = free_start_q[f_raddr];
  assign f_rd_len    = free_len_q[f_raddr];
  assign u_rd_start  = used_start_q[u_raddr];
  assign u_rd_len    = used_len_q[u_raddr];
  assign pos_m1      = pos_q[IDX_W-1:0] - idx_t'(1);
  assign idx_p1      = idx_q + cnt_t'(1);
  assign idx_lt_f    = idx_q < fcnt_q;
  assign idx1_lt_f   = idx_p1 < fcnt_q;
  assign fpos_stop   = !idx_lt_f || (f_rd_start >= seg_start_q);
  assign uhit        = (idx_q < ucnt_q) &&
                       (({1'b0, u_rd_start} + HDR_LEN) == {1'b0, user_q});
  assign rest        = f_rd_len - need_q;
  assign need_remove = rest < HDR_LEN;
  assign init_size   = (arena_q > ARENA_MAX) ? ARENA_MAX : arena_q;
  assign seg_end     = {1'b0, seg_start_q} + seg_len_q;
  assign pt_c        = (idx_q != '0) && (prev_end_q == {1'b0, seg_start_q});
  assign nt_c        = idx_lt_f && (seg_end == {1'b0, f_rd_start});
  assign full_c      = !pt_q && !nt_q && (fcnt_q >= FREE_CAP);

  always_comb begin
    sts_o            = '0;
    sts_o.found      = found_q;
    sts_o.zero_bytes = (alloc_bytes_i == '0);
    sts_o.used_full  = (ucnt_q >= USED_CAP);
    sts_o.full       = full_c;
    sts_o.both       = pt_q && nt_q;
    sts_o.neither    = !pt_q && !nt_q;
    sts_o.out_free   = !out_valid_q || m_ready_i;
    case (cmd_i.op)
      OP_ASCAN:  sts_o.at_end = !idx_lt_f;
      OP_SHDN:   sts_o.at_end = !idx1_lt_f;
      OP_USCAN:  sts_o.at_end = (idx_q >= ucnt_q);
      OP_SHUP:   sts_o.at_end = (idx_q == pos_q);
      default:   sts_o.at_end = 1'b0;
    endcase
    case (cmd_i.op)
      OP_USCAN:  sts_o.hit = uhit;
      OP_FPOS:   sts_o.hit = fpos_stop;
      OP_AGRANT: sts_o.hit = need_remove;
      default:   sts_o.hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q      <= ARENA_MAX;
      fcnt_q       <= '0;
      ucnt_q       <= '0;
      idx_q        <= '0;
      found_q      <= 1'b0;
      pt_q         <= 1'b0;
      nt_q         <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
    end else begin
      if (cfg_we_i) begin
        arena_q <= cfg_wdata_i;
      end
      if (cmd_i.res_en) begin
        out_valid_q  <= 1'b1;
        out_status_q <= cmd_i.res_status;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          idx_q   <= '0;
          found_q <= 1'b0;
        end
        OP_INIT: begin
          ucnt_q <= '0;
          fcnt_q <= (init_size == '0) ? cnt_t'(0) : cnt_t'(1);
        end
        OP_ASCAN: begin
          if (idx_lt_f) begin
            idx_q <= idx_p1;
            if (f_rd_len >= need_q && (!found_q || f_rd_len < best_len_q)) begin
              found_q <= 1'b1;
            end
          end
        end
        OP_AGRANT: begin
          ucnt_q <= ucnt_q + cnt_t'(1);
          if (need_remove) begin
            idx_q <= {1'b0, best_q};
          end
        end
        OP_SHDN: begin
          if (idx1_lt_f) begin
            idx_q <= idx_p1;
          end else begin
            fcnt_q <= fcnt_q - cnt_t'(1);
          end
        end
        OP_USCAN: begin
          idx_q <= uhit ? cnt_t'(0) : idx_p1;
        end
        OP_FPOS: begin
          if (fpos_stop) begin
            pt_q <= pt_c;
            nt_q <= nt_c;
          end else begin
            idx_q <= idx_p1;
          end
        end
        OP_FREL: begin
          if (!full_c) begin
            ucnt_q <= ucnt_q - cnt_t'(1);
            if (pt_q && nt_q) begin
              idx_q <= pos_q;
            end else if (!pt_q && !nt_q) begin
              idx_q <= fcnt_q;
            end
          end
        end
        OP_SHUP: begin
          if (idx_q != pos_q) begin
            idx_q <= idx_q - cnt_t'(1);
          end else begin
            fcnt_q <= fcnt_q + cnt_t'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_en) begin
      out_addr_q <= cmd_i.res_alloc ? addr_q : '0;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        need_q <= {1'b0, alloc_bytes_i} + HDR_LEN;
        user_q <= free_addr_i;
      end
      OP_INIT: begin
        free_start_q[0] <= '0;
        free_len_q[0]   <= init_size;
      end
      OP_ASCAN: begin
        if (idx_lt_f && f_rd_len >= need_q && (!found_q || f_rd_len < best_len_q)) begin
          best_q     <= idx_q[IDX_W-1:0];
          best_len_q <= f_rd_len;
        end
      end
      OP_AGRANT: begin
        addr_q                            <= f_rd_start + HDR_ADDR;
        used_start_q[ucnt_q[IDX_W-1:0]]   <= f_rd_start;
        if (need_remove) begin
          used_len_q[ucnt_q[IDX_W-1:0]] <= f_rd_len;
        end else begin
          used_len_q[ucnt_q[IDX_W-1:0]] <= need_q;
          free_start_q[best_q]          <= f_rd_start + need_q[15:0];
          free_len_q[best_q]            <= rest;
        end
      end
      OP_SHDN: begin
        if (idx1_lt_f) begin
          free_start_q[idx_q[IDX_W-1:0]] <= f_rd_start;
          free_len_q[idx_q[IDX_W-1:0]]   <= f_rd_len;
        end
      end
      OP_USCAN: begin
        if (uhit) begin
          u_q         <= idx_q[IDX_W-1:0];
          seg_start_q <= u_rd_start;
          seg_len_q   <= u_rd_len;
        end
      end
      OP_FPOS: begin
        if (fpos_stop) begin
          pos_q      <= idx_q;
          next_len_q <= f_rd_len;
        end else begin
          prev_end_q <= {1'b0, f_rd_start} + f_rd_len;
          prev_len_q <= f_rd_len;
        end
      end
      OP_FREL: begin
        if (!full_c) begin
          used_start_q[u_q] <= u_rd_start;
          used_len_q[u_q]   <= u_rd_len;
          if (pt_q && nt_q) begin
            free_len_q[pos_m1] <= prev_len_q + seg_len_q + next_len_q;
          end else if (pt_q) begin
            free_len_q[pos_m1] <= prev_len_q + seg_len_q;
          end else if (nt_q) begin
            free_start_q[pos_q[IDX_W-1:0]] <= seg_start_q;
            free_len_q[pos_q[IDX_W-1:0]]   <= next_len_q + seg_len_q;
          end
        end
      end
      OP_SHUP: begin
        if (idx_q != pos_q) begin
          free_start_q[idx_q[IDX_W-1:0]] <= f_rd_start;
          free_len_q[idx_q[IDX_W-1:0]]   <= f_rd_len;
        end else begin
          free_start_q[pos_q[IDX_W-1:0]] <= seg_start_q;
          free_len_q[pos_q[IDX_W-1:0]]   <= seg_len_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_valid_o  = out_valid_q;
  assign m_status_o = out_status_q;
  assign m_addr_o   = out_addr_q;

endmodule
`default_nettype wire

// ----- src/best_fit_heap_allocator_core.sv -----
// Top level of the best-fit heap allocator with coalescing free list
//
// Input stream: one word per request. tuser carries the request kind
// (allocate, free, reinitialize); tdata carries the byte count and the
// user offset to free. Output stream: one word per request, tuser the
// status, tdata the user offset of a granted block (zero otherwise).
// cfg_we_i writes the arena size used by reinitialize.
// Requests are served one at a time. Allocate walks the free table for the
// best fit, then grants it, moving entries down when a free segment is used
// up; free walks the granted table for the block, then the free table for
// its position, moving entries when inserting or merging. The walks go one
// entry per cycle over the 32-entry free and granted tables.
// After reset the block builds one free segment over a 64 KiB arena in its
// boot state, then raises s_axis_tready. A result waits in the output
// register while m_axis_tready is low; the next request is taken meanwhile
// and its own result is held back until that register drains.
`timescale 1ns / 1ps
`default_nettype none
module best_fit_heap_allocator_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [16:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] alloc_bytes, [31:16] free_addr
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] addr
  output logic [1:0]       m_axis_tuser    // [1:0] status
);
  import bfha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfha_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_req_i   (s_axis_tuser),
    .sts_i     (sts),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  bfha_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .alloc_bytes_i (s_axis_tdata[15:0]),
    .free_addr_i   (s_axis_tdata[31:16]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .m_ready_i     (m_axis_tready),
    .m_valid_o     (m_axis_tvalid),
    .m_status_o    (m_axis_tuser),
    .m_addr_o      (m_axis_tdata)
  );

endmodule
`default_nettype wire

// ----- src/bfha_checker.sv -----
// Port-level checks of the allocator and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "best_fit_heap_allocator_core_macros.svh"
module bfha_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);
  import bfha_pkg::*;

  `BFHA_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `BFHA_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `BFHA_ASSERT_IMP(a_addr_zero, m_axis_tvalid && (m_axis_tuser != ST_OK), m_axis_tdata == '0)
  `BFHA_ASSERT_IMP(a_addr_past_hdr, m_axis_tvalid && (m_axis_tdata != '0), m_axis_tdata >= HDR_ADDR)

endmodule

bind best_fit_heap_allocator_core bfha_checker u_bfha_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the best-fit heap allocator core
`timescale 1ns / 1ps
module tb;
  import bfha_pkg::*;

  localparam int HDR = 16;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] addr;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  best_fit_heap_allocator_core DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirror of the allocator tables
  int unsigned arena_size;
  int unsigned fs_start[$], fs_len[$];
  int unsigned us_start[$], us_len[$];
  answer_t     answers_due[$];
  int          err_cnt;
  int          burst_left;
  bit          hold_off;
  bit          sink_stall;

  function automatic void arena_rebuild();
    int unsigned sz;
    sz = arena_size > 65536 ? 65536 : arena_size;
    us_start.delete(); us_len.delete(); fs_start.delete(); fs_len.delete();
    if (sz != 0) begin
      fs_start.push_back(0); fs_len.push_back(sz);
    end
  endfunction

  function automatic answer_t grant_bytes(int unsigned bytes);
    answer_t a;
    int unsigned need, rest;
    int best;
    a = '0;
    best = -1;
    if (bytes == 0) begin
      a.status = ST_BAD; return a;
    end
    if (us_start.size() >= USED_DEPTH) begin
      a.status = ST_FULL; return a;
    end
    need = bytes + HDR;
    foreach (fs_len[i])
      if (fs_len[i] >= need && (best < 0 || fs_len[i] < fs_len[best])) best = i;
    if (best < 0) begin
      a.status = ST_NOFIT; return a;
    end
    us_start.push_back(fs_start[best]);
    rest = fs_len[best] - need;
    if (rest >= HDR) begin
      us_len.push_back(need);
      fs_start[best] += need;
      fs_len[best] = rest;
    end else begin
      us_len.push_back(fs_len[best]);
      fs_start.delete(best); fs_len.delete(best);
    end
    a.status = ST_OK;
    a.addr = 16'(us_start[$] + HDR);
    return a;
  endfunction

  function automatic answer_t release_block(int unsigned user);
    answer_t a;
    int u, pos, last;
    int unsigned st, ln;
    bit pt, nt;
    a = '0;
    u = -1;
    foreach (us_start[i]) if (u < 0 && us_start[i] + HDR == user) u = i;
    if (u < 0) begin
      a.status = ST_BAD; return a;
    end
    st = us_start[u]; ln = us_len[u];
    pos = 0;
    while (pos < fs_start.size() && fs_start[pos] < st) pos++;
    pt = pos > 0 && fs_start[pos-1] + fs_len[pos-1] == st;
    nt = pos < fs_start.size() && st + ln == fs_start[pos];
    if (!pt && !nt && fs_start.size() >= FREE_DEPTH) begin
      a.status = ST_FULL; return a;
    end
    last = us_start.size() - 1;
    us_start[u] = us_start[last]; us_len[u] = us_len[last];
    us_start.delete(last); us_len.delete(last);
    if (pt && nt) begin
      fs_len[pos-1] += ln + fs_len[pos];
      fs_start.delete(pos); fs_len.delete(pos);
    end else if (pt) fs_len[pos-1] += ln;
    else if (nt) begin
      fs_start[pos] = st; fs_len[pos] += ln;
    end else begin
      fs_start.insert(pos, st); fs_len.insert(pos, ln);
    end
    a.status = ST_OK;
    return a;
  endfunction

  function automatic answer_t predict(logic [1:0] req, logic [15:0] bytes, logic [15:0] user);
    answer_t a;
    a = '0;
    case (req)
      REQ_ALLOC: a = grant_bytes(bytes);
      REQ_FREE:  a = release_block(user);
      REQ_INIT: begin
        arena_rebuild();
        a.status = ST_OK;
      end
      default:   a.status = ST_BAD;
    endcase
    return a;
  endfunction

  task automatic report(string what, answer_t got, answer_t want);
    $display("tb: %s mismatch: got status %0d addr %0d, want status %0d addr %0d",
             what, got.status, got.addr, want.status, want.addr);
    err_cnt++;
  endtask

  // sender: bursts of random length with gaps
  task automatic send_word(logic [1:0] req, logic [15:0] bytes, logic [15:0] user);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {user, bytes};
    do @(posedge clk_i); while (!s_axis_tready);
    answers_due.push_back(predict(req, bytes, user));
    burst_left--;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic set_arena(int unsigned sz);
    drain();
    cfg_we_i <= 1'b1; cfg_wdata_i <= 17'(sz);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    arena_size = sz;
  endtask

  // checker
  always @(posedge clk_i) begin
    answer_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser; got.addr = m_axis_tdata;
      if (answers_due.size() == 0) report("unexpected", got, '0);
      else begin
        if (got.status !== answers_due[0].status) report("status", got, answers_due[0]);
        else if (got.addr !== answers_due[0].addr) report("addr", got, answers_due[0]);
        void'(answers_due.pop_front());
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if (sink_stall) m_axis_tready <= ($urandom_range(0, 3) != 0);
    else m_axis_tready <= 1'b1;
  end

  function automatic logic [15:0] pick_user();
    int r;
    r = $urandom_range(0, 9);
    if (us_start.size() != 0 && r < 8)
      return 16'(us_start[$urandom_range(0, us_start.size() - 1)] + HDR);
    return 16'($urandom);
  endfunction

  task automatic test_directed();
    send_word(REQ_INIT, 16'h0000, 16'h0000);
    send_word(REQ_ALLOC, 16'd0, 16'h0000);
    send_word(REQ_ALLOC, 16'hFFFF, 16'hFFFF);
    send_word(REQ_ALLOC, 16'hFFF0, 16'h0000);
    send_word(REQ_FREE, 16'h0000, 16'd16);
    send_word(REQ_FREE, 16'h0000, 16'd16);
    send_word(REQ_ALLOC, 16'd1, 16'h0000);
    send_word(REQ_ALLOC, 16'd100, 16'h0000);
    send_word(REQ_ALLOC, 16'd1, 16'h0000);
    send_word(REQ_FREE, 16'h0000, 16'd48);
    send_word(REQ_FREE, 16'h0000, 16'd16);
    send_word(REQ_FREE, 16'h0000, 16'd180);
    send_word(REQ_RSVD, 16'hFFFF, 16'hFFFF);
    send_word(REQ_FREE, 16'h0000, 16'hFFFF);
    send_word(REQ_INIT, 16'h0000, 16'h0000);
  endtask

  task automatic test_tables_full();
    set_arena(4096);
    send_word(REQ_INIT, 16'h0, 16'h0);
    for (int i = 0; i < 34; i++) send_word(REQ_ALLOC, 16'd16, 16'h0);
    for (int i = 0; i < 32; i += 2) send_word(REQ_FREE, 16'h0, 16'(i * 32 + HDR));
    send_word(REQ_FREE, 16'h0, 16'(31 * 32 + HDR));
    send_word(REQ_ALLOC, 16'd8000, 16'h0);
  endtask

  task automatic test_random(int n, int unsigned sz);
    logic [1:0] req;
    int r;
    set_arena(sz);
    send_word(REQ_INIT, 16'h0, 16'h0);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 50) req = REQ_ALLOC;
      else if (r < 95) req = REQ_FREE;
      else if (r < 98) req = REQ_INIT;
      else req = REQ_RSVD;
      if ($urandom_range(0, 9) == 0)
        send_word(req, 16'($urandom), pick_user());
      else
        send_word(req, 16'($urandom_range(0, sz / 24)), pick_user());
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_word(REQ_ALLOC, 16'd32, 16'h0);
    join
    drain();
    for (int i = 0; i < 8; i++) send_word(REQ_FREE, 16'h0, pick_user());
  endtask

  initial begin
    err_cnt = 0; burst_left = 0; hold_off = 1'b0; sink_stall = 1'b0;
    arena_size = 65536;
    arena_rebuild();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    sink_stall = 1'b1;
    test_tables_full();
    test_backpressure();
    test_random(500, 65536);
    test_random(300, 1024);
    sink_stall = 1'b0;
    test_random(150, 16);
    test_random(100, 131071);
    sink_stall = 1'b1;
    test_random(250, 600);
    set_arena(0);
    send_word(REQ_INIT, 16'h0, 16'h0);
    send_word(REQ_ALLOC, 16'd1, 16'h0);
    send_word(REQ_FREE, 16'h0, 16'd16);
    drain();
    if (err_cnt == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: done, errors");
    $finish;
  end
endmodule
